>>> rtl/core/hdet_pkg.sv
// ----------------------------------------------------------------------------
// hdet_pkg
// Types and constants of the streaming 3x3 Hessian determinant block.
// ----------------------------------------------------------------------------
package hdet_pkg;

   localparam int unsigned PixW       = 16;
   localparam int unsigned DetW       = 40;
   localparam int unsigned RowW       = 12;
   localparam int unsigned ColOutW    = 11;
   localparam int unsigned CfgWidthW  = 12;
   localparam int unsigned CfgHeightW = 13;
   localparam int unsigned LapW       = 18;
   localparam int unsigned ProdW      = 2 * LapW;
   localparam int unsigned CsrDataW   = 32;
   localparam int unsigned CsrAddrW   = 3;

   localparam int unsigned MinDim     = 3;
   localparam int unsigned MaxHeight  = 4096;

   localparam logic [CfgWidthW-1:0]  WidthReset  = 12'd640;
   localparam logic [CfgHeightW-1:0] HeightReset = 13'd480;

   localparam logic RegImageWidth  = 1'b0;
   localparam logic RegImageHeight = 1'b1;

   localparam int unsigned FifoDepth = 8;
   localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
   localparam int unsigned FifoCntW  = FifoPtrW + 1;

   typedef struct packed {
      logic signed [DetW-1:0] det_times16;
      logic [RowW-1:0]        center_row;
      logic [ColOutW-1:0]     center_col;
   } rsp_item_type;

endpackage

>>> rtl/core/hessian_determinant_3x3.sv
// ----------------------------------------------------------------------------
// hessian_determinant_3x3
// Streaming 3x3 Hessian determinant over a raster pixel stream, two line
// stores in synchronous memories, result queue toward the output channel.
// ----------------------------------------------------------------------------
// Pipeline: an interior pixel's result passes the memory read, Laplacian and
// product registers; the final subtract feeds the queue write, and the result
// is offered on rsp from the queue.
// Throughput: one pixel per cycle, set by one read and one write per cycle on
// each line store memory; input stalls only when the eight-entry result queue
// would overflow. Reset clears counters, window, pipeline and queue, and sets
// the frame size to 640 x 480; line stores are not cleared.
module hessian_determinant_3x3 #(
   parameter int unsigned MAX_WIDTH = 2048
) (
   input  logic                                      clock,
   input  logic                                      reset,

   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [hdet_pkg::PixW-1:0]                 req_pixel,
   input  logic                                      req_frame_start,

   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [hdet_pkg::DetW-1:0]          rsp_det_times16,
   output logic [hdet_pkg::RowW-1:0]                 rsp_center_row,
   output logic [hdet_pkg::ColOutW-1:0]              rsp_center_col,

   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [hdet_pkg::CsrAddrW-1:0]             csr_paddr,
   input  logic [hdet_pkg::CsrDataW-1:0]             csr_pwdata,
   output logic [hdet_pkg::CsrDataW-1:0]             csr_prdata,
   output logic                                      csr_pready
);

   localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
   localparam int unsigned WCMP_W = (COL_W + 1 > hdet_pkg::CfgWidthW) ?
                                    COL_W + 1 : hdet_pkg::CfgWidthW;
   localparam int unsigned PIX_W  = hdet_pkg::PixW;
   localparam int unsigned LAP_W  = hdet_pkg::LapW;
   localparam int unsigned PROD_W = hdet_pkg::ProdW;
   localparam int unsigned DET_W  = hdet_pkg::DetW;
   localparam int unsigned ROW_W  = hdet_pkg::RowW;
   localparam int unsigned HGT_W  = hdet_pkg::CfgHeightW;
   localparam int unsigned CNT_W  = hdet_pkg::FifoCntW;
   localparam int unsigned PTR_W  = hdet_pkg::FifoPtrW;

   // configuration
   logic [hdet_pkg::CfgWidthW-1:0]  width_ff;
   logic [HGT_W-1:0]                height_ff;
   logic                            csr_write;

   // counters
   logic [COL_W-1:0]  col_ff, col_in, cur_col;
   logic [ROW_W-1:0]  row_ff, row_in, cur_row;
   logic [WCMP_W-1:0] width_ext, eff_w, col_plus;
   logic [HGT_W-1:0]  eff_h, row_plus;
   logic              col_wrap, row_wrap, req_accept, cur_emit;

   // line stores
   logic [PIX_W-1:0] line_older_ff [MAX_WIDTH];
   logic [PIX_W-1:0] line_newer_ff [MAX_WIDTH];
   logic [PIX_W-1:0] rd_older_ff, rd_newer_ff;

   // stage 1
   logic              st1_valid_ff, st1_emit_ff, st1_fwd_ff;
   logic [COL_W-1:0]  st1_idx_ff;
   logic [PIX_W-1:0]  st1_bot_ff, st1_fwd_top_ff, st1_fwd_mid_ff;
   logic [PIX_W-1:0]  st1_top, st1_mid;
   logic [ROW_W-1:0]  st1_row_ff;
   logic [hdet_pkg::ColOutW-1:0] st1_col_ff;
   logic [PIX_W-1:0]  win_ff [6];
   logic signed [LAP_W-1:0] lxx, lyy, sdiag;

   // stage 2
   logic                    st2_valid_ff;
   logic signed [LAP_W-1:0] st2_lxx_ff, st2_lyy_ff, st2_s_ff;
   logic [ROW_W-1:0]        st2_row_ff;
   logic [hdet_pkg::ColOutW-1:0] st2_col_ff;

   // stage 3
   logic                     st3_valid_ff;
   logic signed [PROD_W-1:0] st3_p_ff, st3_q_ff;
   logic [ROW_W-1:0]         st3_row_ff;
   logic [hdet_pkg::ColOutW-1:0] st3_col_ff;
   logic signed [DET_W-1:0]  det;

   // result queue
   hdet_pkg::rsp_item_type fifo_mem_ff [hdet_pkg::FifoDepth];
   hdet_pkg::rsp_item_type fifo_wdata, fifo_rdata;
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] fifo_cnt_ff, pending;
   logic             fifo_push, fifo_pop;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= hdet_pkg::WidthReset;
         height_ff <= hdet_pkg::HeightReset;
      end else if (csr_write) begin
         case (csr_paddr[2])
            hdet_pkg::RegImageWidth: begin
               width_ff <= csr_pwdata[hdet_pkg::CfgWidthW-1:0];
            end
            hdet_pkg::RegImageHeight: begin
               height_ff <= csr_pwdata[HGT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         hdet_pkg::RegImageWidth:  csr_prdata = hdet_pkg::CsrDataW'(width_ff);
         hdet_pkg::RegImageHeight: csr_prdata = hdet_pkg::CsrDataW'(height_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- counters
   assign req_accept = req_valid & ~req_stall;
   assign cur_col    = req_frame_start ? '0 : col_ff;
   assign cur_row    = req_frame_start ? '0 : row_ff;
   assign cur_emit   = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));

   always_comb begin
      width_ext = WCMP_W'(width_ff);
      if (width_ext < WCMP_W'(hdet_pkg::MinDim)) begin
         eff_w = WCMP_W'(hdet_pkg::MinDim);
      end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         eff_w = WCMP_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ext;
      end
      if (height_ff < HGT_W'(hdet_pkg::MinDim)) begin
         eff_h = HGT_W'(hdet_pkg::MinDim);
      end else if (height_ff > HGT_W'(hdet_pkg::MaxHeight)) begin
         eff_h = HGT_W'(hdet_pkg::MaxHeight);
      end else begin
         eff_h = height_ff;
      end
      col_plus = WCMP_W'(cur_col) + WCMP_W'(1);
      row_plus = HGT_W'(cur_row) + HGT_W'(1);
      col_wrap = col_plus >= eff_w;
      row_wrap = row_plus >= eff_h;
      if (col_wrap) begin
         col_in = '0;
         row_in = row_wrap ? '0 : row_plus[ROW_W-1:0];
      end else begin
         col_in = col_plus[COL_W-1:0];
         row_in = cur_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- line stores
   assign st1_top = st1_fwd_ff ? st1_fwd_top_ff : rd_older_ff;
   assign st1_mid = st1_fwd_ff ? st1_fwd_mid_ff : rd_newer_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rd_older_ff <= line_older_ff[cur_col];
         rd_newer_ff <= line_newer_ff[cur_col];
      end
      if (st1_valid_ff) begin
         line_older_ff[st1_idx_ff] <= st1_mid;
         line_newer_ff[st1_idx_ff] <= st1_bot_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1
   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st1_emit_ff  <= 1'b0;
         st1_fwd_ff   <= 1'b0;
      end else begin
         st1_valid_ff <= req_accept;
         if (req_accept) begin
            st1_emit_ff <= cur_emit;
            st1_fwd_ff  <= st1_valid_ff && (st1_idx_ff == cur_col);
         end
      end
   end

   // forward the entry that the item ahead writes back in this same cycle
   always_ff @(posedge clock) begin
      if (req_accept) begin
         st1_idx_ff     <= cur_col;
         st1_bot_ff     <= req_pixel;
         st1_fwd_top_ff <= st1_mid;
         st1_fwd_mid_ff <= st1_bot_ff;
         st1_row_ff     <= cur_row - ROW_W'(1);
         st1_col_ff     <= hdet_pkg::ColOutW'(cur_col - COL_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (st1_valid_ff) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= st1_top;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= st1_mid;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= st1_bot_ff;
      end
   end

   always_comb begin
      lxx   = $signed(LAP_W'(win_ff[2])) - ($signed(LAP_W'(win_ff[3])) <<< 1)
              + $signed(LAP_W'(st1_mid));
      lyy   = $signed(LAP_W'(win_ff[1])) - ($signed(LAP_W'(win_ff[3])) <<< 1)
              + $signed(LAP_W'(win_ff[5]));
      sdiag = $signed(LAP_W'(st1_top)) - $signed(LAP_W'(win_ff[0]))
              + $signed(LAP_W'(win_ff[4])) - $signed(LAP_W'(st1_bot_ff));
   end

   // ---------------------------------------------------------------- stage 2
   always_ff @(posedge clock) begin
      if (reset) begin
         st2_valid_ff <= 1'b0;
      end else begin
         st2_valid_ff <= st1_valid_ff & st1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      st2_lxx_ff <= lxx;
      st2_lyy_ff <= lyy;
      st2_s_ff   <= sdiag;
      st2_row_ff <= st1_row_ff;
      st2_col_ff <= st1_col_ff;
   end

   // ---------------------------------------------------------------- stage 3
   always_ff @(posedge clock) begin
      if (reset) begin
         st3_valid_ff <= 1'b0;
      end else begin
         st3_valid_ff <= st2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      st3_p_ff   <= st2_lxx_ff * st2_lyy_ff;
      st3_q_ff   <= st2_s_ff * st2_s_ff;
      st3_row_ff <= st2_row_ff;
      st3_col_ff <= st2_col_ff;
   end

   assign det = (DET_W'(st3_p_ff) <<< 4) - DET_W'(st3_q_ff);

   // ---------------------------------------------------------------- result queue
   assign fifo_wdata.det_times16 = det;
   assign fifo_wdata.center_row  = st3_row_ff;
   assign fifo_wdata.center_col  = st3_col_ff;

   assign fifo_push = st3_valid_ff;
   assign fifo_pop  = rsp_valid & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (fifo_push) begin
         fifo_mem_ff[wr_ptr_ff] <= fifo_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (fifo_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (fifo_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (fifo_push && !fifo_pop) begin
            fifo_cnt_ff <= fifo_cnt_ff + CNT_W'(1);
         end else if (!fifo_push && fifo_pop) begin
            fifo_cnt_ff <= fifo_cnt_ff - CNT_W'(1);
         end
      end
   end

   // hold input while queued and in-flight results could overflow the queue
   assign pending   = fifo_cnt_ff + CNT_W'(st1_valid_ff & st1_emit_ff)
                      + CNT_W'(st2_valid_ff) + CNT_W'(st3_valid_ff);
   assign req_stall = pending >= CNT_W'(hdet_pkg::FifoDepth);

   assign fifo_rdata      = fifo_mem_ff[rd_ptr_ff];
   assign rsp_valid       = fifo_cnt_ff != '0;
   assign rsp_det_times16 = fifo_rdata.det_times16;
   assign rsp_center_row  = fifo_rdata.center_row;
   assign rsp_center_col  = fifo_rdata.center_col;

   // ---------------------------------------------------------------- assertions
   a_fifo_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(fifo_push && !fifo_pop && fifo_cnt_ff == CNT_W'(hdet_pkg::FifoDepth)))
      else $error("result queue overflow");

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending <= CNT_W'(hdet_pkg::FifoDepth))
      else $error("more results in flight than queue entries");

   a_forward_same_entry: assert property (@(posedge clock) disable iff (reset)
      req_accept && st1_valid_ff && (cur_col == st1_idx_ff) |=> st1_fwd_ff)
      else $error("same-entry read missed forwarding");

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      WCMP_W'(col_ff) < WCMP_W'(MAX_WIDTH))
      else $error("column counter beyond line store depth");

endmodule
